>>> rtl/core/fsgs_pkg.sv
// Shared types and constants for the falling sand grid block.
// No dependencies; every other file but fsgs_ram refers to it by scoped names.

package fsgs_pkg;

  // Fixed widths of the command word fields
  localparam int CMD_W = 2;
  localparam int ROW_W = 5;
  localparam int COL_W = 5;
  localparam int OUT_W = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PLACE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // Columns resolved per sweep step
  localparam int COLS_PER_STEP = 8;

  // Read address select
  typedef enum logic [1:0] {
    RD_REQ,     // row named by the command word
    RD_BOTTOM,  // last grid row
    RD_UP,      // current upper row of the sweep pair
    RD_NEXT     // row above the current upper row
  } rd_sel_t;

  // Write address/data select
  typedef enum logic [1:0] {
    WR_PLACE,   // requested row with the new grain
    WR_DN,      // finished lower row of the sweep pair
    WR_TOP      // top row at the end of a sweep
  } wr_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    clr;
    logic    sw_init;
    logic    cap_dn;
    logic    cap_up;
    logic    step;
    logic    shift;
    logic    out_en;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_chunk;
    logic r_zero;
  } sts_t;

endpackage

>>> rtl/core/falling_sand_grid_step_top.sv
// Top level of the falling sand grid block: controller plus datapath.
// Depends on fsgs_pkg, fsgs_ctrl, fsgs_dp, fsgs_ram.
//
// Usage:
//   A command word (cmd, row, col) is taken on a rising edge with start high
//   and busy low. cmd: place grain, run one sweep, read row, clear grid.
//   Each command answers with one word: row_bits holds the addressed row
//   after the command, marked by done for exactly one cycle. The receiver
//   cannot hold done off; row_bits stays put until the next answer.
//   A sweep rereads one row from the row store per row pair and resolves
//   8 columns per cycle.
//   busy is high from the cycle after accept until done; a new command may
//   be issued in the done cycle. One command is in flight at a time.
//   Reset (rst, synchronous) empties the grid at once through per-row
//   valid bits, drops any command in flight and leaves the block idle.
//   Rows at or past GRID_SIZE read as zero; places outside are dropped.

module falling_sand_grid_step_top #(
  parameter int GRID_SIZE = 32   // 3 .. 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [fsgs_pkg::CMD_W-1:0]       cmd,
  input  logic [fsgs_pkg::ROW_W-1:0]       row,
  input  logic [fsgs_pkg::COL_W-1:0]       col,
  output logic                             busy,
  output logic                             done,
  output logic [fsgs_pkg::OUT_W-1:0]       row_bits
);

  // Command and status between sequencer and datapath
  fsgs_pkg::ctl_t ctl;
  fsgs_pkg::sts_t sts;

  fsgs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  fsgs_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .row      (row),
    .col      (col),
    .ctl      (ctl),
    .sts      (sts),
    .row_bits (row_bits)
  );

endmodule

>>> rtl/core/fsgs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.

module fsgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/fsgs_ctrl.sv
// Sequencer for the falling sand grid: decodes the command word and steps
// the datapath. Depends on fsgs_pkg.

module fsgs_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fsgs_pkg::CMD_W-1:0] cmd,
  input  fsgs_pkg::sts_t             sts,
  output fsgs_pkg::ctl_t             ctl,
  output logic                       busy,
  output logic                       done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PL_RD,
    S_PL_WR,
    S_SW_BOT,
    S_SW_DN,
    S_SW_UP,
    S_SW_STEP,
    S_SW_WB,
    S_SW_TOP,
    S_CLR,
    S_RD,
    S_RD_DATA
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start && !busy) begin
          ctl.load = 1'b1;
          unique case (cmd)
            fsgs_pkg::CMD_PLACE: state_next = S_PL_RD;
            fsgs_pkg::CMD_SWEEP: state_next = S_SW_BOT;
            fsgs_pkg::CMD_READ:  state_next = S_RD;
            fsgs_pkg::CMD_CLEAR: state_next = S_CLR;
          endcase
        end
      end
      S_PL_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = fsgs_pkg::RD_REQ;
        state_next = S_PL_WR;
      end
      S_PL_WR: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = fsgs_pkg::WR_PLACE;
        state_next = S_RD;
      end
      S_SW_BOT: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_sel  = fsgs_pkg::RD_BOTTOM;
        ctl.sw_init = 1'b1;
        state_next  = S_SW_DN;
      end
      S_SW_DN: begin
        ctl.cap_dn = 1'b1;
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = fsgs_pkg::RD_UP;
        state_next = S_SW_UP;
      end
      S_SW_UP: begin
        ctl.cap_up = 1'b1;
        state_next = S_SW_STEP;
      end
      S_SW_STEP: begin
        ctl.step = 1'b1;
        if (sts.last_chunk) begin
          state_next = S_SW_WB;
        end
      end
      S_SW_WB: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = fsgs_pkg::WR_DN;
        ctl.shift  = 1'b1;
        if (sts.r_zero) begin
          state_next = S_SW_TOP;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = fsgs_pkg::RD_NEXT;
          state_next = S_SW_UP;
        end
      end
      S_SW_TOP: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = fsgs_pkg::WR_TOP;
        state_next = S_RD;
      end
      S_CLR: begin
        ctl.clr    = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = fsgs_pkg::RD_REQ;
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        ctl.out_en = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state == S_RD_DATA);
    end
  end

endmodule

>>> rtl/core/fsgs_dp.sv
// Datapath for the falling sand grid: row store, row valid bits, sweep
// pair registers and the per-step column resolver. Depends on fsgs_pkg, fsgs_ram.

module fsgs_dp #(
  parameter int GRID_SIZE = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [fsgs_pkg::ROW_W-1:0]       row,
  input  logic [fsgs_pkg::COL_W-1:0]       col,
  input  fsgs_pkg::ctl_t                   ctl,
  output fsgs_pkg::sts_t                   sts,
  output logic [fsgs_pkg::OUT_W-1:0]       row_bits
);

  localparam int AW   = $clog2(GRID_SIZE);
  localparam int NCH  = (GRID_SIZE + fsgs_pkg::COLS_PER_STEP - 1) / fsgs_pkg::COLS_PER_STEP;
  localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PW   = NCH * fsgs_pkg::COLS_PER_STEP;
  localparam int PIW  = $clog2(PW);
  localparam int LB   = $clog2(fsgs_pkg::COLS_PER_STEP);

  // Latched command word
  logic [fsgs_pkg::ROW_W-1:0] row_q;
  logic [fsgs_pkg::COL_W-1:0] col_q;
  logic                       row_ok;
  logic                       place_ok;
  logic [AW-1:0]              row_addr;

  // Row store and its valid bits (unwritten rows read as empty)
  logic [(1 << AW)-1:0]       valid;
  logic                       vld_q;
  logic [GRID_SIZE-1:0]       ram_q;
  logic [GRID_SIZE-1:0]       rd_row;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       we;
  logic [AW-1:0]              wr_addr;
  logic [GRID_SIZE-1:0]       wr_data;
  logic [GRID_SIZE-1:0]       place_data;

  // Sweep pair
  logic [GRID_SIZE-1:0]       up_reg;
  logic [GRID_SIZE-1:0]       dn_reg;
  logic [GRID_SIZE-1:0]       up_n;
  logic [GRID_SIZE-1:0]       dn_n;
  logic [PW-1:0]              up_p;
  logic [PW-1:0]              dn_p;
  logic [AW-1:0]              r;
  logic [CW-1:0]              chunk;

  logic [GRID_SIZE+fsgs_pkg::OUT_W-1:0] out_ext;

  assign row_ok   = (32'(row_q) < GRID_SIZE);
  assign place_ok = row_ok && (32'(col_q) < GRID_SIZE);
  assign row_addr = AW'(row_q);

  assign rd_row     = vld_q ? ram_q : '0;
  assign place_data = rd_row | (GRID_SIZE'(1) << col_q);
  assign out_ext    = {{fsgs_pkg::OUT_W{1'b0}}, rd_row};

  assign sts.last_chunk = (chunk == CW'(NCH - 1));
  assign sts.r_zero     = (r == '0);

  assign rd_en = ctl.rd_en;

  always_comb begin
    unique case (ctl.rd_sel)
      fsgs_pkg::RD_REQ:    rd_addr = row_addr;
      fsgs_pkg::RD_BOTTOM: rd_addr = AW'(GRID_SIZE - 1);
      fsgs_pkg::RD_UP:     rd_addr = r;
      fsgs_pkg::RD_NEXT:   rd_addr = r - 1'b1;
    endcase
  end

  always_comb begin
    unique case (ctl.wr_sel)
      fsgs_pkg::WR_PLACE: begin
        wr_addr = row_addr;
        wr_data = place_data;
      end
      fsgs_pkg::WR_DN: begin
        wr_addr = r + 1'b1;
        wr_data = dn_reg;
      end
      fsgs_pkg::WR_TOP: begin
        wr_addr = '0;
        wr_data = dn_reg;
      end
      default: begin
        wr_addr = '0;
        wr_data = dn_reg;
      end
    endcase
  end

  // A place outside the grid is dropped
  assign we = ctl.wr_en && ((ctl.wr_sel != fsgs_pkg::WR_PLACE) || place_ok);

  fsgs_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clr) begin
      valid <= '0;
    end else if (we) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_q <= valid[rd_addr];
    end
  end

  // One step resolves COLS_PER_STEP columns, left to right, in order
  always_comb begin
    logic [PIW-1:0] c;
    logic [PIW-1:0] cl;
    logic [PIW-1:0] cr;
    up_p = PW'(up_reg);
    dn_p = PW'(dn_reg);
    for (int j = 0; j < fsgs_pkg::COLS_PER_STEP; j++) begin
      c  = PIW'({chunk, LB'(j)});
      cl = (c != '0) ? c - 1'b1 : c;
      cr = (32'(c) < PW - 1) ? c + 1'b1 : c;
      if ((32'(c) < GRID_SIZE) && up_p[c]) begin
        if (!dn_p[c]) begin
          dn_p[c] = 1'b1;
          up_p[c] = 1'b0;
        end else if ((c != '0) && !dn_p[cl]) begin
          dn_p[cl] = 1'b1;
          up_p[c]  = 1'b0;
        end else if ((32'(c) != GRID_SIZE - 1) && !dn_p[cr]) begin
          dn_p[cr] = 1'b1;
          up_p[c]  = 1'b0;
        end
      end
    end
    up_n = up_p[GRID_SIZE-1:0];
    dn_n = dn_p[GRID_SIZE-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      row_q <= row;
      col_q <= col;
    end
    if (ctl.sw_init) begin
      r <= AW'(GRID_SIZE - 2);
    end
    if (ctl.cap_dn) begin
      dn_reg <= rd_row;
    end
    if (ctl.cap_up) begin
      up_reg <= rd_row;
      chunk  <= '0;
    end
    if (ctl.step) begin
      up_reg <= up_n;
      dn_reg <= dn_n;
      chunk  <= chunk + 1'b1;
    end
    if (ctl.shift) begin
      dn_reg <= up_reg;
      r      <= r - 1'b1;
    end
    if (ctl.out_en) begin
      row_bits <= row_ok ? out_ext[fsgs_pkg::OUT_W-1:0] : '0;
    end
  end

endmodule

>>> rtl/core/fsgs_chk.sv
// Port-level checks for the falling sand grid top level, with its bind.
// Depends on fsgs_pkg and falling_sand_grid_step_top.

module fsgs_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic [fsgs_pkg::CMD_W-1:0] cmd,
  input logic                       busy,
  input logic                       done
);

  // Accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // Answer comes with busy already low
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // busy only drops together with an answer
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without an answer");

  // Read answers once the sequencer has passed S_RD and S_RD_DATA
  a_read_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == fsgs_pkg::CMD_READ)) |-> ##3 done)
    else $error("read latency wrong");

  // Strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held more than one cycle");

endmodule

bind falling_sand_grid_step_top fsgs_chk u_fsgs_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .cmd   (cmd),
  .busy  (busy),
  .done  (done)
);
